@@ rtl/core/ihc_pkg.sv @@
// ihc_pkg: shared types, codes and helper functions for the ipv4 header check
// no dependencies

package ihc_pkg;

    localparam int unsigned HdrWords      = 10;
    localparam int unsigned IdxW          = 4;
    localparam logic [3:0]  IpVersionFour = 4'd4;
    localparam logic [5:0]  MinHdrBytes   = 6'd20;
    localparam logic [16:0] LinkHdrBytes  = 17'd14;
    localparam logic [15:0] FragMask      = 16'h3FFF;
    localparam logic [15:0] SumGood       = 16'hFFFF;
    localparam logic [7:0]  ProtoIcmp     = 8'd1;
    localparam logic [7:0]  ProtoUdp      = 8'd17;

    typedef enum logic [2:0] {
        V_ACCEPT    = 3'd0,
        V_VERSION   = 3'd1,
        V_SHORT_HDR = 3'd2,
        V_FRAME     = 3'd3,
        V_HDR_TOTAL = 3'd4,
        V_CHECKSUM  = 3'd5,
        V_ADDRESS   = 3'd6
    } t_verdict;

    typedef enum logic [1:0] {
        C_ICMP  = 2'd0,
        C_UDP   = 2'd1,
        C_OTHER = 2'd2
    } t_proto_class;

    typedef enum logic [0:0] {
        REG_LOCAL_ADDR = 1'b0,
        REG_SUBNET     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  ver_len;
        logic [15:0] total_len;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] frame_len;
        logic [15:0] csum;
    } t_hdr;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return 16'(s[15:0] + {15'b0, s[16]});
    endfunction

    function automatic logic is_bcast(input logic [31:0] ip, input logic [31:0] lcl,
                                      input logic [31:0] mask);
        logic hit;
        if (ip == 32'h0 || ip == 32'hFFFF_FFFF) begin
            hit = 1'b1;
        end else if (ip == lcl) begin
            hit = 1'b0;
        end else begin
            hit = ((ip & mask) == (lcl & mask)) && ((ip & ~mask) == ~mask);
        end
        return hit;
    endfunction

endpackage

@@ rtl/core/ipv4_header_receive_check.sv @@
// ipv4_header_receive_check: one header word accepted per cycle while results drain,
// a sum and latch stage, then a check stage and result register; the tenth beat is
// latched into the header record, then the result beat is held in the result register until taken.
// throughput one beat per cycle while results drain; one result beat per header.
// synchronous active-low reset clears word count, sums, stage valids and config registers.
// depends on ihc_pkg, ihc_accum, ihc_verdict

module ipv4_header_receive_check import ihc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_header_word,
    input  logic        i_first_word,
    input  logic [15:0] i_frame_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_verdict,
    output logic        o_is_fragment,
    output logic [1:0]  o_protocol_class,
    output logic [7:0]  o_protocol_number,
    output logic [15:0] o_datagram_length
);

    logic [31:0] r_local_addr;
    logic [31:0] r_subnet_mask;
    t_hdr        hdr;
    logic        hdr_vld;
    logic        hdr_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr  <= '0;
            r_subnet_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_LOCAL_ADDR: r_local_addr  <= i_cfg_wdata;
                REG_SUBNET:     r_subnet_mask <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    ihc_accum u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_header_word  (i_header_word),
        .i_first_word   (i_first_word),
        .i_frame_length (i_frame_length),
        .i_hdr_adv      (hdr_adv),
        .o_in_ready     (o_in_ready),
        .o_hdr          (hdr),
        .o_hdr_vld      (hdr_vld)
    );

    ihc_verdict u_verdict (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_hdr             (hdr),
        .i_hdr_vld         (hdr_vld),
        .i_local_addr      (r_local_addr),
        .i_subnet_mask     (r_subnet_mask),
        .i_out_ready       (i_out_ready),
        .o_hdr_adv         (hdr_adv),
        .o_out_valid       (o_out_valid),
        .o_verdict         (o_verdict),
        .o_is_fragment     (o_is_fragment),
        .o_protocol_class  (o_protocol_class),
        .o_protocol_number (o_protocol_number),
        .o_datagram_length (o_datagram_length)
    );

    // stalled header record blocks input
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hdr_vld && !hdr_adv) |-> !o_in_ready)
        else $error("input taken while header record stalled");

    // header record moving on reaches the result register
    a_hdr_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hdr_vld && hdr_adv) |=> o_out_valid)
        else $error("header record lost");

    // stalled header record holds its contents
    a_hdr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hdr_vld && !hdr_adv) |=> (hdr_vld && $stable(hdr)))
        else $error("stalled header record changed");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict <= 3'd6 && o_protocol_class <= 2'd2))
        else $error("result code out of range");

endmodule

@@ rtl/core/ihc_accum.sv @@
// ihc_accum: word counter, running ones-complement sum and header field latches
// hands a complete header record to the check stage; depends on ihc_pkg

module ihc_accum import ihc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [15:0] i_header_word,
    input  logic        i_first_word,
    input  logic [15:0] i_frame_length,
    input  logic        i_hdr_adv,
    output logic        o_in_ready,
    output t_hdr        o_hdr,
    output logic        o_hdr_vld
);

    logic [IdxW-1:0] r_idx, n_idx;
    logic [IdxW-1:0] cur_idx;
    t_hdr            r_acc, n_acc;
    t_hdr            r_hdr;
    logic            r_hdr_vld;
    logic            accept;
    logic            active;
    logic            done;

    assign o_in_ready = !r_hdr_vld || i_hdr_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign cur_idx    = i_first_word ? '0 : r_idx;
    assign active     = cur_idx < IdxW'(HdrWords);
    assign done       = accept && active && (cur_idx == IdxW'(HdrWords - 1));

    always_comb begin
        n_acc = r_acc;
        n_idx = r_idx;
        if (accept) begin
            n_idx = cur_idx;
            if (active) begin
                if (cur_idx == '0) begin
                    n_acc.frame_len = i_frame_length;
                    n_acc.csum      = i_header_word;
                end else begin
                    n_acc.csum = ones_add(r_acc.csum, i_header_word);
                end
                case (cur_idx)
                    4'd0:    n_acc.ver_len   = i_header_word[15:8];
                    4'd1:    n_acc.total_len = i_header_word;
                    4'd3:    n_acc.frag      = i_header_word;
                    4'd4:    n_acc.proto     = i_header_word[7:0];
                    4'd6:    n_acc.src[31:16] = i_header_word;
                    4'd7:    n_acc.src[15:0]  = i_header_word;
                    4'd8:    n_acc.dst[31:16] = i_header_word;
                    4'd9:    n_acc.dst[15:0]  = i_header_word;
                    default: ;
                endcase
                n_idx = cur_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_acc     <= '0;
            r_hdr_vld <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_acc <= n_acc;
            if (done) begin
                r_hdr_vld <= 1'b1;
            end else if (i_hdr_adv) begin
                r_hdr_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_hdr <= n_acc;
        end
    end

    assign o_hdr     = r_hdr;
    assign o_hdr_vld = r_hdr_vld;

endmodule

@@ rtl/core/ihc_verdict.sv @@
// ihc_verdict: header checks in priority order and the result register
// depends on ihc_pkg

module ihc_verdict import ihc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_hdr        i_hdr,
    input  logic        i_hdr_vld,
    input  logic [31:0] i_local_addr,
    input  logic [31:0] i_subnet_mask,
    input  logic        i_out_ready,
    output logic        o_hdr_adv,
    output logic        o_out_valid,
    output logic [2:0]  o_verdict,
    output logic        o_is_fragment,
    output logic [1:0]  o_protocol_class,
    output logic [7:0]  o_protocol_number,
    output logic [15:0] o_datagram_length
);

    logic         r_vld;
    t_verdict     r_verdict, n_verdict;
    t_proto_class r_class, n_class;
    logic         r_frag;
    logic [7:0]   r_proto;
    logic [15:0]  r_dlen;
    logic [5:0]   hlen;
    logic         dst_ok;
    logic         src_bad;

    assign o_hdr_adv = !r_vld || i_out_ready;
    assign hlen      = {i_hdr.ver_len[3:0], 2'b00};
    assign dst_ok    = (i_hdr.dst == i_local_addr) ||
                       is_bcast(i_hdr.dst, i_local_addr, i_subnet_mask);
    assign src_bad   = is_bcast(i_hdr.src, i_local_addr, i_subnet_mask);

    always_comb begin
        if (i_hdr.ver_len[7:4] != IpVersionFour) begin
            n_verdict = V_VERSION;
        end else if (hlen < MinHdrBytes) begin
            n_verdict = V_SHORT_HDR;
        end else if ({1'b0, i_hdr.frame_len} < ({1'b0, i_hdr.total_len} + LinkHdrBytes)) begin
            n_verdict = V_FRAME;
        end else if ({10'b0, hlen} > i_hdr.total_len) begin
            n_verdict = V_HDR_TOTAL;
        end else if (i_hdr.csum != SumGood) begin
            n_verdict = V_CHECKSUM;
        end else if (!dst_ok || src_bad) begin
            n_verdict = V_ADDRESS;
        end else begin
            n_verdict = V_ACCEPT;
        end
        if (i_hdr.proto == ProtoIcmp) begin
            n_class = C_ICMP;
        end else if (i_hdr.proto == ProtoUdp) begin
            n_class = C_UDP;
        end else begin
            n_class = C_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_hdr_adv) begin
            r_vld <= i_hdr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_hdr_adv && i_hdr_vld) begin
            r_verdict <= n_verdict;
            r_class   <= n_class;
            r_frag    <= (i_hdr.frag & FragMask) != 16'h0;
            r_proto   <= i_hdr.proto;
            r_dlen    <= i_hdr.total_len;
        end
    end

    assign o_out_valid       = r_vld;
    assign o_verdict         = r_verdict;
    assign o_is_fragment     = r_frag;
    assign o_protocol_class  = r_class;
    assign o_protocol_number = r_proto;
    assign o_datagram_length = r_dlen;

endmodule
